// File: src/aad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aad_pkg
// Shared widths, codes and types for the area-average downscaler.
// ----------------------------------------------------------------------------
package aad_pkg;

  localparam int PIX_W     = 8;
  localparam int SUM_W     = 33;
  localparam int WGT_W     = 25;
  localparam int IN_DIM_W  = 13;
  localparam int OUT_DIM_W = 9;
  localparam int SPLIT_W   = 2 * OUT_DIM_W;
  localparam int PROD_W    = PIX_W + SPLIT_W;
  localparam int CNT_W     = 22;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  localparam logic CMD_ACCUM = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef enum logic [1:0] {
    REG_IN_WIDTH   = 2'd0,
    REG_IN_HEIGHT  = 2'd1,
    REG_OUT_WIDTH  = 2'd2,
    REG_OUT_HEIGHT = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [SUM_W-1:0] s0;
    logic [SUM_W-1:0] s1;
    logic [SUM_W-1:0] s2;
    logic [WGT_W-1:0] w;
  } aad_entry_t;

endpackage

// File: src/aad_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aad_in_if
// Input channel: command and one pixel of three colour channels.
// ----------------------------------------------------------------------------
interface aad_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] chan0;
  logic [7:0] chan1;
  logic [7:0] chan2;

  modport source (output valid, output command, output chan0, output chan1,
                  output chan2, input ready);
  modport sink   (input valid, input command, input chan0, input chan1,
                  input chan2, output ready);
endinterface

// File: src/aad_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aad_out_if
// Result channel: one averaged output pixel with last and error flags.
// ----------------------------------------------------------------------------
interface aad_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_chan0;
  logic [7:0] out_chan1;
  logic [7:0] out_chan2;
  logic       last;
  logic       error;

  modport source (output valid, output out_chan0, output out_chan1,
                  output out_chan2, output last, output error, input ready);
  modport sink   (input valid, input out_chan0, input out_chan1,
                  input out_chan2, input last, input error, output ready);
endinterface

// File: src/area_average_downscaler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// area_average_downscaler_core
// Area-averaging downscaler: accumulates weighted pixels, reads out averages.
// ----------------------------------------------------------------------------
// Accumulate transaction: accepted in S_IDLE, then S_A_CALC, S_A_READ and
// S_A_WRITE for each covered output pixel (read-modify-write of the
// accumulator memory), and S_A_CALC alone for each skipped slot. Read
// transaction: a touched output pixel runs its three channels in turn through
// the shared bit-serial divider. Reset, any register write and the end of a
// frame start a clearing pass over all OUT_MAX_DIM*OUT_MAX_DIM entries, during which no pixel is taken.
// ----------------------------------------------------------------------------
module area_average_downscaler_core
  import aad_pkg::*;
#(
  parameter int IN_MAX_DIM  = 4096,
  parameter int OUT_MAX_DIM = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  aad_in_if.sink             in_ch,
  aad_out_if.source          out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int ENTRIES = OUT_MAX_DIM * OUT_MAX_DIM;
  localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_A_CALC, S_A_READ, S_A_WRITE,
    S_R_READ, S_R_LOAD, S_R_DIV, S_R_DONE
  } state_t;

  state_t state_r;

  // configuration
  logic [IN_DIM_W-1:0]  in_w_r, in_h_r;
  logic [OUT_DIM_W-1:0] out_w_r, out_h_r;
  logic                 cfg_wr;
  reg_idx_t             cfg_idx;
  logic                 cfg_ok;

  // frame position, tracked as quotient and remainder of position*out/in
  logic [IN_DIM_W-1:0]  col_r, row_r;
  logic [IN_DIM_W-1:0]  rem_x_r, rem_y_r;
  logic [OUT_DIM_W-1:0] dx_r, dy_r;
  logic [ADDR_W-1:0]    rd_idx_r;

  // captured pixel split
  logic [OUT_DIM_W-1:0] xi0_r, xi1_r, xw0_r, xw1_r;
  logic [OUT_DIM_W-1:0] yi0_r, yi1_r, yw0_r, yw1_r;
  logic                 two_x_r, two_y_r;
  logic [PIX_W-1:0]     c0_r, c1_r, c2_r;
  logic [1:0]           sub_r;
  logic [ADDR_W-1:0]    addr_r;
  logic [SPLIT_W-1:0]   w_r;
  logic [PROD_W-1:0]    p0_r, p1_r, p2_r;

  // accumulator memory
  aad_entry_t           mem [ENTRIES];
  aad_entry_t           rdata_r;
  aad_entry_t           mem_wdata;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [ADDR_W-1:0]    clr_addr_r;

  // readout
  logic [1:0]           ch_r;
  logic [PIX_W-1:0]     res_r [3];
  logic                 res_err_r, res_last_r;
  logic                 out_valid_r;
  logic [PIX_W-1:0]     out_c0_r, out_c1_r, out_c2_r;
  logic                 out_last_r, out_err_r;

  logic                 div_start, div_done;
  logic [SUM_W-1:0]     div_dvd;
  logic [PIX_W-1:0]     div_quot;
  logic [1:0]           div_ch;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_comb begin
    unique case (cfg_idx)
      REG_IN_WIDTH:   prdata = PDATA_W'(in_w_r);
      REG_IN_HEIGHT:  prdata = PDATA_W'(in_h_r);
      REG_OUT_WIDTH:  prdata = PDATA_W'(out_w_r);
      REG_OUT_HEIGHT: prdata = PDATA_W'(out_h_r);
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    cfg_ok = (in_w_r != '0) && ({1'b0, in_w_r} <= 14'(IN_MAX_DIM)) &&
             (in_h_r != '0) && ({1'b0, in_h_r} <= 14'(IN_MAX_DIM)) &&
             (out_w_r != '0) && ({2'b0, out_w_r} <= 11'(OUT_MAX_DIM)) &&
             (out_h_r != '0) && ({2'b0, out_h_r} <= 11'(OUT_MAX_DIM)) &&
             (IN_DIM_W'(out_w_r) <= in_w_r) && (IN_DIM_W'(out_h_r) <= in_h_r);
  end

  // ---------------------------------------------------------------------------
  // split of the current pixel along x and y
  // ---------------------------------------------------------------------------
  logic [IN_DIM_W:0]    sx, sy, nin_x, nin_y;
  logic                 two_x, two_y, adv_x, adv_y;
  logic [OUT_DIM_W-1:0] xw0, xw1, yw0, yw1;
  logic [IN_DIM_W:0]    dx_sub, dy_sub;
  logic                 row_end;

  always_comb begin
    nin_x  = {1'b0, in_w_r};
    nin_y  = {1'b0, in_h_r};
    sx     = {1'b0, rem_x_r} + (IN_DIM_W + 1)'(out_w_r);
    sy     = {1'b0, rem_y_r} + (IN_DIM_W + 1)'(out_h_r);
    two_x  = sx > nin_x;
    two_y  = sy > nin_y;
    adv_x  = sx >= nin_x;
    adv_y  = sy >= nin_y;
    dx_sub = nin_x - {1'b0, rem_x_r};
    dy_sub = nin_y - {1'b0, rem_y_r};
    xw0    = two_x ? dx_sub[OUT_DIM_W-1:0] : out_w_r;
    yw0    = two_y ? dy_sub[OUT_DIM_W-1:0] : out_h_r;
    xw1    = OUT_DIM_W'(sx - nin_x);
    yw1    = OUT_DIM_W'(sy - nin_y);
    row_end = ({1'b0, col_r} + 1'b1) >= nin_x;
  end

  // ---------------------------------------------------------------------------
  // entry address and weight for the current slot of the 2x2 footprint
  // ---------------------------------------------------------------------------
  logic                 sub_ok;
  logic [OUT_DIM_W-1:0] xi_s, yi_s, xw_s, yw_s;
  logic [CNT_W-1:0]     e_acc;
  logic [SPLIT_W-1:0]   w_acc;

  always_comb begin
    sub_ok = (!sub_r[0] || two_x_r) && (!sub_r[1] || two_y_r);
    xi_s   = sub_r[0] ? xi1_r : xi0_r;
    xw_s   = sub_r[0] ? xw1_r : xw0_r;
    yi_s   = sub_r[1] ? yi1_r : yi0_r;
    yw_s   = sub_r[1] ? yw1_r : yw0_r;
    e_acc  = CNT_W'(yi_s) * CNT_W'(out_w_r) + CNT_W'(xi_s);
    w_acc  = SPLIT_W'(xw_s) * SPLIT_W'(yw_s);
  end

  // ---------------------------------------------------------------------------
  // readout index
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]  total;
  logic [ADDR_W-1:0] e_rd;
  logic              rd_last;

  always_comb begin
    total   = CNT_W'(out_w_r) * CNT_W'(out_h_r);
    e_rd    = (CNT_W'(rd_idx_r) >= total) ? '0 : rd_idx_r;
    rd_last = (CNT_W'(e_rd) + 1'b1) >= total;
  end

  // ---------------------------------------------------------------------------
  // accumulator memory
  // ---------------------------------------------------------------------------
  always_comb begin
    mem_we    = (state_r == S_CLEAR) || (state_r == S_A_WRITE);
    mem_waddr = (state_r == S_CLEAR) ? clr_addr_r : addr_r;
    if (state_r == S_CLEAR) begin
      mem_wdata = '0;
    end else begin
      mem_wdata.s0 = rdata_r.s0 + SUM_W'(p0_r);
      mem_wdata.s1 = rdata_r.s1 + SUM_W'(p1_r);
      mem_wdata.s2 = rdata_r.s2 + SUM_W'(p2_r);
      mem_wdata.w  = rdata_r.w + WGT_W'(w_r);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[addr_r];
  end

  // ---------------------------------------------------------------------------
  // shared divider
  // ---------------------------------------------------------------------------
  always_comb begin
    div_ch    = (state_r == S_R_LOAD) ? 2'd0 : ch_r + 2'd1;
    div_start = ((state_r == S_R_LOAD) && (rdata_r.w != '0)) ||
                ((state_r == S_R_DIV) && div_done && (ch_r != 2'd2));
    unique case (div_ch)
      2'd0:    div_dvd = rdata_r.s0;
      2'd1:    div_dvd = rdata_r.s1;
      default: div_dvd = rdata_r.s2;
    endcase
  end

  aad_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (rdata_r.w),
    .done     (div_done),
    .quot     (div_quot)
  );

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  logic in_acc, out_acc, out_load;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_acc  = out_valid_r && out_ch.ready;
  assign out_load = (state_r == S_R_DONE) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      in_w_r      <= IN_DIM_W'(1);
      in_h_r      <= IN_DIM_W'(1);
      out_w_r     <= OUT_DIM_W'(1);
      out_h_r     <= OUT_DIM_W'(1);
      col_r       <= '0;
      row_r       <= '0;
      rem_x_r     <= '0;
      rem_y_r     <= '0;
      dx_r        <= '0;
      dy_r        <= '0;
      rd_idx_r    <= '0;
      sub_r       <= '0;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // drop the output only when no new result replaces it this cycle
      if (out_acc && !(out_load && !cfg_wr)) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_IN_WIDTH:   in_w_r  <= pwdata[IN_DIM_W-1:0];
          REG_IN_HEIGHT:  in_h_r  <= pwdata[IN_DIM_W-1:0];
          REG_OUT_WIDTH:  out_w_r <= pwdata[OUT_DIM_W-1:0];
          REG_OUT_HEIGHT: out_h_r <= pwdata[OUT_DIM_W-1:0];
          default: ;
        endcase
        col_r      <= '0;
        row_r      <= '0;
        rem_x_r    <= '0;
        rem_y_r    <= '0;
        dx_r       <= '0;
        dy_r       <= '0;
        rd_idx_r   <= '0;
        clr_addr_r <= '0;
        state_r    <= S_CLEAR;
      end else begin
        unique case (state_r)
          S_CLEAR: begin
            if (clr_addr_r == ADDR_W'(ENTRIES - 1)) begin
              state_r <= S_IDLE;
            end else begin
              clr_addr_r <= clr_addr_r + 1'b1;
            end
          end
          S_IDLE: begin
            if (in_acc) begin
              if (in_ch.command == CMD_READ) begin
                if (!cfg_ok) begin
                  res_r[0]   <= '0;
                  res_r[1]   <= '0;
                  res_r[2]   <= '0;
                  res_err_r  <= 1'b1;
                  res_last_r <= 1'b1;
                  state_r    <= S_R_DONE;
                end else begin
                  addr_r     <= e_rd;
                  res_last_r <= rd_last;
                  state_r    <= S_R_READ;
                end
              end else if (cfg_ok && (row_r < in_h_r)) begin
                xi0_r   <= dx_r;
                xi1_r   <= dx_r + 1'b1;
                xw0_r   <= xw0;
                xw1_r   <= xw1;
                two_x_r <= two_x;
                yi0_r   <= dy_r;
                yi1_r   <= dy_r + 1'b1;
                yw0_r   <= yw0;
                yw1_r   <= yw1;
                two_y_r <= two_y;
                c0_r    <= in_ch.chan0;
                c1_r    <= in_ch.chan1;
                c2_r    <= in_ch.chan2;
                sub_r   <= '0;
                state_r <= S_A_CALC;
                // advance the raster position
                if (row_end) begin
                  col_r   <= '0;
                  rem_x_r <= '0;
                  dx_r    <= '0;
                  row_r   <= row_r + 1'b1;
                  rem_y_r <= adv_y ? IN_DIM_W'(sy - nin_y) : IN_DIM_W'(sy);
                  dy_r    <= adv_y ? dy_r + 1'b1 : dy_r;
                end else begin
                  col_r   <= col_r + 1'b1;
                  rem_x_r <= adv_x ? IN_DIM_W'(sx - nin_x) : IN_DIM_W'(sx);
                  dx_r    <= adv_x ? dx_r + 1'b1 : dx_r;
                end
              end
            end
          end
          S_A_CALC: begin
            if (sub_ok) begin
              addr_r  <= e_acc[ADDR_W-1:0];
              w_r     <= w_acc;
              state_r <= S_A_READ;
            end else if (sub_r == 2'd3) begin
              state_r <= S_IDLE;
            end else begin
              sub_r <= sub_r + 1'b1;
            end
          end
          S_A_READ: begin
            p0_r    <= PROD_W'(c0_r) * PROD_W'(w_r);
            p1_r    <= PROD_W'(c1_r) * PROD_W'(w_r);
            p2_r    <= PROD_W'(c2_r) * PROD_W'(w_r);
            state_r <= S_A_WRITE;
          end
          S_A_WRITE: begin
            if (sub_r == 2'd3) begin
              state_r <= S_IDLE;
            end else begin
              sub_r   <= sub_r + 1'b1;
              state_r <= S_A_CALC;
            end
          end
          S_R_READ: begin
            state_r <= S_R_LOAD;
          end
          S_R_LOAD: begin
            res_r[0]  <= '0;
            res_r[1]  <= '0;
            res_r[2]  <= '0;
            ch_r      <= '0;
            // an untouched output pixel reports an error
            res_err_r <= (rdata_r.w == '0);
            state_r   <= (rdata_r.w == '0) ? S_R_DONE : S_R_DIV;
          end
          S_R_DIV: begin
            if (div_done) begin
              res_r[ch_r] <= div_quot;
              if (ch_r == 2'd2) begin
                state_r <= S_R_DONE;
              end else begin
                ch_r <= ch_r + 1'b1;
              end
            end
          end
          S_R_DONE: begin
            if (out_load) begin
              out_c0_r    <= res_r[0];
              out_c1_r    <= res_r[1];
              out_c2_r    <= res_r[2];
              out_err_r   <= res_err_r;
              out_last_r  <= res_last_r;
              out_valid_r <= 1'b1;
              if (res_last_r) begin
                col_r      <= '0;
                row_r      <= '0;
                rem_x_r    <= '0;
                rem_y_r    <= '0;
                dx_r       <= '0;
                dy_r       <= '0;
                rd_idx_r   <= '0;
                clr_addr_r <= '0;
                state_r    <= S_CLEAR;
              end else begin
                rd_idx_r <= addr_r + 1'b1;
                state_r  <= S_IDLE;
              end
            end
          end
          default: state_r <= S_IDLE;
        endcase
      end
    end
  end

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_chan0 = out_c0_r;
  assign out_ch.out_chan1 = out_c1_r;
  assign out_ch.out_chan2 = out_c2_r;
  assign out_ch.last      = out_last_r;
  assign out_ch.error     = out_err_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_R_DIV))
    else $error("divider finished outside the divide phase");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && res_last_r && !cfg_wr) |=> (state_r == S_CLEAR))
    else $error("frame not cleared after last readout");

  a_weight_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_A_READ) |-> (w_r != '0))
    else $error("zero weight reached the accumulator");

endmodule

// File: src/aad_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aad_div
// Restoring divider, one quotient bit per cycle; keeps the low quotient byte.
// ----------------------------------------------------------------------------
module aad_div
  import aad_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [WGT_W-1:0] divisor,
  output logic             done,
  output logic [PIX_W-1:0] quot
);

  localparam int STEP_W = $clog2(SUM_W);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [SUM_W-1:0]  dvd_r;
  logic [WGT_W-1:0]  dvs_r;
  logic [WGT_W-1:0]  rem_r;
  logic [PIX_W-1:0]  q_r;

  logic [WGT_W:0]    trial;
  logic [WGT_W:0]    diff;
  logic              ge;
  logic [WGT_W-1:0]  rem_nxt;

  always_comb begin
    trial   = {rem_r, dvd_r[SUM_W-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = (trial >= {1'b0, dvs_r});
    rem_nxt = ge ? diff[WGT_W-1:0] : trial[WGT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dvd_r  <= dividend;
        dvs_r  <= divisor;
        rem_r  <= '0;
        q_r    <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        dvd_r <= {dvd_r[SUM_W-2:0], 1'b0};
        q_r   <= {q_r[PIX_W-2:0], ge};
        if (cnt_r == STEP_W'(SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// File: dv/aad_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aad_tb_if
// Testbench-side helpers: result record for the downscaler's output channel.
// ----------------------------------------------------------------------------
package aad_tb_pkg;

  typedef struct {
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic       last;
    logic       err;
  } px_result_t;

endpackage

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for area_average_downscaler_core: drives pixel and
// readout transactions, predicts each averaged output pixel with an
// area-weight model of its own and compares every field of every result.
// ----------------------------------------------------------------------------
module tb;
  import aad_pkg::*;
  import aad_tb_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  aad_in_if  in_ch ();
  aad_out_if out_ch ();

  area_average_downscaler_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Predictor state
  int unsigned cfg_in_w, cfg_in_h, cfg_out_w, cfg_out_h;
  longint unsigned acc_c0 [int];
  longint unsigned acc_c1 [int];
  longint unsigned acc_c2 [int];
  int unsigned     acc_wgt [int];
  int unsigned     pos_col, pos_row, rd_idx;

  px_result_t expected_px[$];
  int         mismatches;
  int         items_sent;
  int         results_seen;
  int         frames_done;
  bit         idle_en;
  int         long_hold_req;
  int         long_hold_seen;
  int         stall_cnt;

  function automatic void frame_clear();
    acc_c0.delete();
    acc_c1.delete();
    acc_c2.delete();
    acc_wgt.delete();
    pos_col = 0;
    pos_row = 0;
    rd_idx  = 0;
  endfunction

  function automatic bit cfg_ok();
    if (cfg_in_w < 1 || cfg_in_w > 4096) return 0;
    if (cfg_in_h < 1 || cfg_in_h > 4096) return 0;
    if (cfg_out_w < 1 || cfg_out_w > 256) return 0;
    if (cfg_out_h < 1 || cfg_out_h > 256) return 0;
    if (cfg_out_w > cfg_in_w || cfg_out_h > cfg_in_h) return 0;
    return 1;
  endfunction

  // Split one coordinate into up to two output cells and their coverage.
  function automatic int coverage_split(int unsigned pos, int unsigned n_in,
                                        int unsigned n_out,
                                        output int unsigned idx[2],
                                        output int unsigned wt[2]);
    int unsigned cx, d1, d2, w1;
    cx = pos * n_out;
    d1 = cx / n_in;
    d2 = (cx + n_out) / n_in;
    idx[0] = d1;
    wt[0]  = n_out;
    idx[1] = 0;
    wt[1]  = 0;
    if (d1 == d2) return 1;
    w1 = d2 * n_in - cx;
    if (w1 >= n_out) return 1;
    wt[0]  = w1;
    idx[1] = d2;
    wt[1]  = n_out - w1;
    return 2;
  endfunction

  function automatic void accumulate_px(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
    int unsigned xi[2], xw[2], yi[2], yw[2];
    int nx, ny;
    int unsigned w, e;
    if (pos_row >= cfg_in_h) return;
    nx = coverage_split(pos_col, cfg_in_w, cfg_out_w, xi, xw);
    ny = coverage_split(pos_row, cfg_in_h, cfg_out_h, yi, yw);
    for (int b = 0; b < ny; b++) begin
      for (int a = 0; a < nx; a++) begin
        w = xw[a] * yw[b];
        if (w == 0 || xi[a] >= cfg_out_w || yi[b] >= cfg_out_h) continue;
        e = yi[b] * cfg_out_w + xi[a];
        if (e >= 65536) continue;
        if (!acc_wgt.exists(e)) begin
          acc_c0[e] = 0; acc_c1[e] = 0; acc_c2[e] = 0; acc_wgt[e] = 0;
        end
        acc_c0[e]  = (acc_c0[e] + longint'(c0) * w) & 64'h1_FFFF_FFFF;
        acc_c1[e]  = (acc_c1[e] + longint'(c1) * w) & 64'h1_FFFF_FFFF;
        acc_c2[e]  = (acc_c2[e] + longint'(c2) * w) & 64'h1_FFFF_FFFF;
        acc_wgt[e] = (acc_wgt[e] + w) & 32'h1FF_FFFF;
      end
    end
    pos_col++;
    if (pos_col >= cfg_in_w) begin
      pos_col = 0;
      pos_row++;
    end
  endfunction

  function automatic px_result_t readout_px();
    px_result_t r;
    int unsigned total, e;
    longint unsigned w;
    r = '{c0: 8'd0, c1: 8'd0, c2: 8'd0, last: 1'b0, err: 1'b0};
    if (!cfg_ok()) begin
      r.last = 1'b1;
      r.err  = 1'b1;
      frame_clear();
      return r;
    end
    total = cfg_out_w * cfg_out_h;
    e = rd_idx;
    if (e >= total) e = 0;
    if (!acc_wgt.exists(e) || acc_wgt[e] == 0) begin
      r.err = 1'b1;
    end else begin
      w = acc_wgt[e];
      r.c0 = 8'(acc_c0[e] / w);
      r.c1 = 8'(acc_c1[e] / w);
      r.c2 = 8'(acc_c2[e] / w);
    end
    if (e + 1 >= total) begin
      r.last = 1'b1;
      frame_clear();
    end else begin
      rd_idx = e + 1;
    end
    return r;
  endfunction

  // Offer one transaction and hold it until the block takes it.
  task automatic send_item(logic cmd, logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.chan0   <= c0;
    in_ch.chan1   <= c1;
    in_ch.chan2   <= c2;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    if (cmd == CMD_READ) expected_px = {expected_px, readout_px()};
    else if (cfg_ok()) accumulate_px(c0, c1, c2);
  endtask

  task automatic send_random_px();
    send_item(CMD_ACCUM, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Release the input and let the block finish before a register change.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_px.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_write(reg_idx_t idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_IN_WIDTH:   cfg_in_w  = value & 32'h1FFF;
      REG_IN_HEIGHT:  cfg_in_h  = value & 32'h1FFF;
      REG_OUT_WIDTH:  cfg_out_w = value & 32'h1FF;
      REG_OUT_HEIGHT: cfg_out_h = value & 32'h1FF;
    endcase
    frame_clear();
  endtask

  task automatic set_geometry(int unsigned iw, int unsigned ih, int unsigned ow,
                              int unsigned oh);
    drain();
    cfg_write(REG_IN_WIDTH, iw);
    cfg_write(REG_IN_HEIGHT, ih);
    cfg_write(REG_OUT_WIDTH, ow);
    cfg_write(REG_OUT_HEIGHT, oh);
  endtask

  // Reset values: a 1x1 frame; pixels after the first are ignored.
  task automatic test_reset_geometry();
    send_item(CMD_ACCUM, 8'h5A, 8'hA5, 8'h00);
    send_item(CMD_ACCUM, 8'hFF, 8'hFF, 8'hFF);
    send_item(CMD_READ, 8'hFF, 8'h00, 8'hFF);
  endtask

  task automatic test_invalid_geometry();
    set_geometry(0, 4, 1, 1);
    send_item(CMD_ACCUM, 8'h11, 8'h22, 8'h33);
    send_item(CMD_READ, 8'h00, 8'h00, 8'h00);
    set_geometry(8191, 8191, 511, 511);
    send_item(CMD_READ, 8'h00, 8'h00, 8'h00);
    set_geometry(4, 2, 5, 3);
    send_item(CMD_READ, 8'h00, 8'h00, 8'h00);
  endtask

  // Largest geometry, read early: covered cells and never-touched cells.
  task automatic test_max_geometry();
    set_geometry(4096, 4096, 256, 256);
    for (int i = 0; i < 40; i++) begin
      if (i[0]) send_item(CMD_ACCUM, 8'hFF, 8'h00, 8'hFF);
      else send_item(CMD_ACCUM, 8'h00, 8'hFF, 8'h00);
    end
    repeat (4) send_item(CMD_READ, 8'h00, 8'h00, 8'h00);
  endtask

  // Whole frames of random geometry, with early reads and surplus pixels mixed in.
  task automatic test_random_frames(int unsigned item_goal);
    int unsigned iw, ih, ow, oh, n_pix;
    while (items_sent < item_goal) begin
      iw = $urandom_range(1, 24);
      ih = $urandom_range(1, 16);
      ow = $urandom_range(1, iw < 8 ? iw : 8);
      oh = $urandom_range(1, ih < 6 ? ih : 6);
      if (items_sent > item_goal - 250) idle_en = 1'b0;
      set_geometry(iw, ih, ow, oh);
      n_pix = iw * ih;
      for (int i = 0; i < n_pix; i++) begin
        if ($urandom_range(0, 40) == 0 && rd_idx + 2 < ow * oh)
          send_item(CMD_READ, 8'($urandom), 8'($urandom), 8'($urandom));
        send_random_px();
      end
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 5)) send_random_px();
      if (frames_done == 1) long_hold_req++;
      while (1) begin
        send_item(CMD_READ, 8'($urandom), 8'($urandom), 8'($urandom));
        if (expected_px[$].last) break;
      end
      frames_done++;
    end
  endtask

  // Result side: random stalls plus a requested long hold.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready   <= 1'b0;
      stall_cnt      <= 0;
      long_hold_seen <= long_hold_req;
    end else if (long_hold_seen != long_hold_req) begin
      out_ch.ready   <= 1'b0;
      stall_cnt      <= 500;
      long_hold_seen <= long_hold_req;
    end else if (stall_cnt > 0) begin
      out_ch.ready <= 1'b0;
      stall_cnt    <= stall_cnt - 1;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      out_ch.ready <= 1'b0;
      stall_cnt    <= $urandom_range(0, 3);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_px.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output pixel at %0t", $realtime);
      end else begin
        px_result_t exp_px;
        exp_px = expected_px.pop_front();
        if (out_ch.out_chan0 !== exp_px.c0 || out_ch.out_chan1 !== exp_px.c1 ||
            out_ch.out_chan2 !== exp_px.c2 || out_ch.last !== exp_px.last ||
            out_ch.error !== exp_px.err) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"pixel mismatch at %0t: exp %h %h %h last %b err %b, ",
                      "got %h %h %h last %b err %b"},
                     $realtime, exp_px.c0, exp_px.c1, exp_px.c2, exp_px.last, exp_px.err,
                     out_ch.out_chan0, out_ch.out_chan1, out_ch.out_chan2, out_ch.last,
                     out_ch.error);
        end
      end
    end
  end

  initial begin
    #200ms;
    $display("area_average_downscaler_core test failed");
    $finish;
  end

  initial begin
    rst_n         <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.command <= CMD_ACCUM;
    in_ch.chan0   <= '0;
    in_ch.chan1   <= '0;
    in_ch.chan2   <= '0;
    cfg_in_w  = 1;
    cfg_in_h  = 1;
    cfg_out_w = 1;
    cfg_out_h = 1;
    frame_clear();
    mismatches    = 0;
    items_sent    = 0;
    results_seen  = 0;
    frames_done   = 0;
    long_hold_req = 0;
    idle_en       = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_geometry();
    test_invalid_geometry();
    test_max_geometry();
    test_random_frames(950);

    drain();
    repeat (150) @(posedge clk);
    if (expected_px.size() != 0) mismatches++;
    $display("Sent %0d transactions, checked %0d output pixels over %0d random frames.",
             items_sent, results_seen, frames_done);
    $display("Covered reset, invalid and maximum geometry, early reads and surplus pixels.");
    if (mismatches == 0) begin
      $display("area_average_downscaler_core test passed");
    end else begin
      $display("area_average_downscaler_core test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/aad_pkg.sv
src/aad_in_if.sv
src/aad_out_if.sv
src/aad_div.sv
src/area_average_downscaler_core.sv
dv/aad_tb_if.sv
dv/tb.sv
